// File: sv/hbrp_pkg.sv
// Package for the HTTP byte-range parser: payload and stage types, phase codes,
// character constants and the saturating number helpers.
// Depends on nothing.
package hbrp_pkg;

   localparam int OFFSET_BITS = 64;
   localparam int SIZE_BITS   = 63;
   localparam int CHAR_BITS   = 8;
   localparam int WIDE_BITS   = SIZE_BITS + 1;

   typedef logic [OFFSET_BITS-1:0]        mag_type;
   typedef logic signed [OFFSET_BITS-1:0] off_type;
   typedef logic [CHAR_BITS-1:0]          char_type;

   localparam mag_type OFF_CAP   = mag_type'(1) << (OFFSET_BITS - 1);
   localparam mag_type OFF_MAX   = OFF_CAP - mag_type'(1);
   localparam mag_type CAP_DIV10 = OFF_CAP / 10;

   localparam char_type CH_NUL   = 8'h00;
   localparam char_type CH_TAB   = 8'h09;
   localparam char_type CH_CR    = 8'h0D;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_PLUS  = 8'h2B;
   localparam char_type CH_COMMA = 8'h2C;
   localparam char_type CH_DASH  = 8'h2D;
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_NINE  = 8'h39;

   localparam logic [2:0] PREFIX_CHARS = 3'd6;

   typedef enum logic [3:0] {
      PH_PREFIX,
      PH_LEAD,
      PH_AWS,
      PH_ASGN,
      PH_ADIG,
      PH_DASH,
      PH_BWS,
      PH_BSGN,
      PH_BDIG,
      PH_DONE,
      PH_FAIL
   } phase_type;

   typedef enum logic [1:0] {
      NS_START,
      NS_SIGN,
      NS_DIGITS
   } nsub_type;

   typedef struct packed {
      char_type             ch;
      logic                 last;
      logic [SIZE_BITS-1:0] total_size;
   } req_type;

   typedef struct packed {
      logic                 satisfiable;
      logic [SIZE_BITS-1:0] first_byte;
      logic [SIZE_BITS-1:0] last_byte;
   } rsp_type;

   typedef struct packed {
      phase_type phase;
      mag_type   accum;
      logic      neg;
      mag_type   first;
      logic      suffix;
      logic      open;
      mag_type   fs;
   } snap_type;

   typedef struct packed {
      logic    parse_ok;
      logic    suffix;
      logic    open;
      mag_type first;
      off_type second;
      mag_type fs;
   } res_type;

   typedef struct packed {
      logic    ok;
      off_type start;
      off_type stop;
      off_type fs;
   } span_type;

   function automatic char_type prefix_char(input logic [2:0] pos);
      char_type c;
      begin
         unique case (pos)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h3D;
            default: c = CH_NUL;
         endcase
         return c;
      end
   endfunction

   function automatic logic is_space(input char_type c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic mag_type sat_pos(input mag_type acc);
      return (acc > OFF_MAX) ? OFF_MAX : acc;
   endfunction

   function automatic mag_type add_digit(input mag_type acc, input logic [3:0] d);
      logic [OFFSET_BITS:0] wide;
      logic [OFFSET_BITS:0] prod;
      mag_type              res;
      begin
         wide = {1'b0, acc};
         prod = (wide << 3) + (wide << 1) + (OFFSET_BITS + 1)'(d);
         if (acc > CAP_DIV10) begin
            res = OFF_CAP;
         end else if (prod > {1'b0, OFF_CAP}) begin
            res = OFF_CAP;
         end else begin
            res = prod[OFFSET_BITS-1:0];
         end
         return res;
      end
   endfunction

endpackage

// File: sv/http_byte_range_parser.sv
// Top level of the HTTP byte-range parser: character parser, verdict pipeline
// and output register. Depends on hbrp_pkg.
//
// Usage
//   req channel: one Range header character per transfer (ch, last, total_size).
//   The header is sent character by character; the transfer with last = 1
//   closes it and carries the file size. A NUL character ends the string
//   early; later characters up to the last one are ignored.
//   rsp channel: exactly one verdict per header (satisfiable, first_byte,
//   last_byte), both offsets zero when the range is not satisfiable.
// Timing
//   One character per cycle while req_ready is high: each character needs one
//   compare and one saturating times-ten accumulate in the parse stage. The
//   verdict passes the snapshot, end-of-string resolve, range arithmetic and
//   bound-check registers before it is presented on the rsp channel.
// Reset and stall
//   Reset empties every stage and returns the parser to prefix matching.
//   A stalled rsp channel holds the verdict in the output register; the three
//   verdict stages keep filling behind it, and req_ready drops only when a
//   last character cannot move into a full pipeline.
module http_byte_range_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hbrp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hbrp_pkg::rsp_type rsp_data
);
   import hbrp_pkg::*;

   req_type    s0_ff;
   logic       s0_v_ff;
   phase_type  phase_ff, phase_in;
   logic [2:0] pos_ff, pos_in;
   mag_type    accum_ff, accum_in;
   logic       neg_ff, neg_in;
   mag_type    first_ff, first_in;
   logic       suffix_ff, suffix_in;
   logic       open_ff, open_in;

   snap_type   s1_ff, s1_in;
   logic       s1_v_ff;
   res_type    s2_ff, s2_in;
   logic       s2_v_ff;
   span_type   s3_ff, s3_in;
   logic       s3_v_ff;
   rsp_type    out_ff, out_in;
   logic       out_v_ff;

   logic       s0_adv, s1_ready, s2_ready, s3_ready, out_ready;

   char_type   ch;
   logic       is_digit;
   logic       run_num;
   logic       second;
   nsub_type   sub;
   mag_type    acc_e;
   logic       neg_e;
   logic [WIDE_BITS-1:0] fs_ext;

   off_type    fs2, fs2_m1, first2;
   off_type    fs3, start3, stop3;
   logic       ok3;

   assign out_ready = !out_v_ff || rsp_ready;
   assign s3_ready  = !s3_v_ff || out_ready;
   assign s2_ready  = !s2_v_ff || s3_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign s0_adv    = s0_v_ff && (!s0_ff.last || s1_ready);
   assign req_ready = !s0_v_ff || s0_adv;

   assign ch       = s0_ff.ch;
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      accum_in  = accum_ff;
      neg_in    = neg_ff;
      first_in  = first_ff;
      suffix_in = suffix_ff;
      open_in   = open_ff;
      run_num   = 1'b0;
      second    = 1'b0;
      sub       = NS_START;
      acc_e     = accum_ff;
      neg_e     = neg_ff;
      if (phase_ff != PH_DONE && phase_ff != PH_FAIL) begin
         if (ch == CH_NUL) begin
            unique case (phase_ff)
               PH_ADIG: begin
                  if (suffix_ff && !neg_ff && accum_ff != '0) begin
                     first_in = sat_pos(accum_ff);
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_BDIG: phase_in = PH_DONE;
               PH_DASH: begin
                  open_in  = 1'b1;
                  phase_in = PH_DONE;
               end
               default: phase_in = PH_FAIL;
            endcase
         end else begin
            unique case (phase_ff)
               PH_PREFIX: begin
                  if (pos_ff < PREFIX_CHARS && ch == prefix_char(pos_ff)) begin
                     pos_in = pos_ff + 3'd1;
                     if (pos_ff == PREFIX_CHARS - 3'd1) begin
                        phase_in = PH_LEAD;
                     end
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_LEAD: begin
                  if (ch != CH_SPACE) begin
                     accum_in = '0;
                     neg_in   = 1'b0;
                     acc_e    = '0;
                     neg_e    = 1'b0;
                     phase_in = PH_AWS;
                     if (ch == CH_DASH) begin
                        suffix_in = 1'b1;
                     end else begin
                        run_num = 1'b1;
                     end
                  end
               end
               PH_AWS: run_num = 1'b1;
               PH_ASGN: begin
                  run_num = 1'b1;
                  sub     = NS_SIGN;
               end
               PH_ADIG: begin
                  run_num = 1'b1;
                  sub     = NS_DIGITS;
               end
               PH_DASH: begin
                  if (ch == CH_COMMA) begin
                     open_in  = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     acc_e   = '0;
                     neg_e   = 1'b0;
                     second  = 1'b1;
                     run_num = 1'b1;
                  end
               end
               PH_BWS: begin
                  second  = 1'b1;
                  run_num = 1'b1;
               end
               PH_BSGN: begin
                  second  = 1'b1;
                  run_num = 1'b1;
                  sub     = NS_SIGN;
               end
               PH_BDIG: begin
                  second  = 1'b1;
                  run_num = 1'b1;
                  sub     = NS_DIGITS;
               end
               default: phase_in = PH_FAIL;
            endcase
         end
      end

      if (run_num) begin
         accum_in = acc_e;
         neg_in   = neg_e;
         if (is_digit) begin
            accum_in = add_digit(acc_e, 4'(ch - CH_ZERO));
            phase_in = second ? PH_BDIG : PH_ADIG;
         end else begin
            case (sub)
               NS_START: begin
                  if (is_space(ch)) begin
                     phase_in = second ? PH_BWS : PH_AWS;
                  end else if (ch == CH_PLUS) begin
                     phase_in = second ? PH_BSGN : PH_ASGN;
                  end else if (ch == CH_DASH) begin
                     neg_in   = 1'b1;
                     phase_in = second ? PH_BSGN : PH_ASGN;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               NS_SIGN: phase_in = PH_FAIL;
               default: begin
                  if (second) begin
                     phase_in = PH_DONE;
                  end else if (suffix_ff) begin
                     if (!neg_e && acc_e != '0) begin
                        first_in = sat_pos(acc_e);
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end else if ((neg_e && acc_e != '0) || ch != CH_DASH) begin
                     phase_in = PH_FAIL;
                  end else begin
                     first_in = sat_pos(acc_e);
                     accum_in = '0;
                     neg_in   = 1'b0;
                     phase_in = PH_DASH;
                  end
               end
            endcase
         end
      end
   end

   assign fs_ext = {1'b0, s0_ff.total_size};

   always_comb begin
      s1_in.phase  = phase_in;
      s1_in.accum  = accum_in;
      s1_in.neg    = neg_in;
      s1_in.first  = first_in;
      s1_in.suffix = suffix_in;
      s1_in.open   = open_in;
      s1_in.fs     = (fs_ext > WIDE_BITS'(OFF_MAX)) ? OFF_MAX : OFFSET_BITS'(fs_ext);
   end

   always_comb begin
      s2_in.suffix   = s1_ff.suffix;
      s2_in.open     = s1_ff.open;
      s2_in.first    = s1_ff.first;
      s2_in.fs       = s1_ff.fs;
      s2_in.second   = s1_ff.neg ? off_type'(-s1_ff.accum) : off_type'(sat_pos(s1_ff.accum));
      s2_in.parse_ok = 1'b0;
      unique case (s1_ff.phase) inside
         PH_ADIG: begin
            s2_in.parse_ok = s1_ff.suffix && !s1_ff.neg && s1_ff.accum != '0;
            s2_in.first    = sat_pos(s1_ff.accum);
         end
         PH_BDIG, PH_DONE: s2_in.parse_ok = 1'b1;
         PH_DASH: begin
            s2_in.parse_ok = 1'b1;
            s2_in.open     = 1'b1;
         end
         default: s2_in.parse_ok = 1'b0;
      endcase
   end

   assign fs2    = off_type'(s2_ff.fs);
   assign fs2_m1 = fs2 - off_type'(1);
   assign first2 = off_type'(s2_ff.first);

   always_comb begin
      s3_in.fs = fs2;
      s3_in.ok = s2_ff.parse_ok && (fs2 > off_type'(0));
      if (s2_ff.suffix) begin
         s3_in.start = (fs2 > first2) ? (fs2 - first2) : off_type'(0);
         s3_in.stop  = fs2_m1;
      end else begin
         s3_in.start = first2;
         s3_in.stop  = s2_ff.open ? fs2_m1 : s2_ff.second;
      end
   end

   assign fs3    = s3_ff.fs;
   assign start3 = s3_ff.start;
   assign stop3  = s3_ff.stop;
   assign ok3    = s3_ff.ok && !(start3 >= fs3) && !(start3 > stop3);

   always_comb begin
      out_in.satisfiable = ok3;
      out_in.first_byte  = '0;
      out_in.last_byte   = '0;
      if (ok3) begin
         out_in.first_byte = SIZE_BITS'(start3[OFFSET_BITS-2:0]);
         if (stop3 >= fs3) begin
            out_in.last_byte = fs3[OFFSET_BITS-2:0] - SIZE_BITS'(1);
         end else begin
            out_in.last_byte = SIZE_BITS'(stop3[OFFSET_BITS-2:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (s0_adv && s0_ff.last)) begin
         phase_ff  <= PH_PREFIX;
         pos_ff    <= '0;
         accum_ff  <= '0;
         neg_ff    <= 1'b0;
         first_ff  <= '0;
         suffix_ff <= 1'b0;
         open_ff   <= 1'b0;
      end else if (s0_adv) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         accum_ff  <= accum_in;
         neg_ff    <= neg_in;
         first_ff  <= first_in;
         suffix_ff <= suffix_in;
         open_ff   <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s0_v_ff <= req_valid;
         end
         if (s1_ready) begin
            s1_v_ff <= s0_adv && s0_ff.last;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_ready) begin
            s3_v_ff <= s2_v_ff;
         end
         if (out_ready) begin
            out_v_ff <= s3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s0_ff <= req_data;
      end
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
      if (out_ready) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

// File: sv/hbrp_checker.sv
// Port-level checks for the HTTP byte-range parser, bound to the top level.
// Depends on hbrp_pkg and http_byte_range_parser.
module hbrp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hbrp_pkg::rsp_type rsp_data
);
   import hbrp_pkg::*;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.satisfiable) |->
         (rsp_data.first_byte == '0 && rsp_data.last_byte == '0))
      else $error("unsatisfiable verdict carries nonzero offsets");

   a_ordered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.satisfiable) |-> (rsp_data.first_byte <= rsp_data.last_byte))
      else $error("range start above range end");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result transfer changed");

   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input held off without a stalled result");

endmodule

bind http_byte_range_parser hbrp_checker u_hbrp_checker (.*);
